// ===== hdl/rdc_pkg.sv =====
package rdc_pkg;

  localparam int VALUE_W = 31;
  localparam int DIGIT_W = 6;
  localparam int RADIX_W = 6;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

  // register index taken from paddr[2]
  localparam logic REG_RADIX = 1'b0;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_result_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [DIGIT_W-1:0] data;
  } stack_cmd_t;

endpackage

// ===== hdl/rdc_div.sv =====
module rdc_div import rdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [RADIX_W-1:0] divisor,
  output div_result_t        result
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, quo[VALUE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule

// ===== hdl/rdc_stack.sv =====
module rdc_stack import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stack_cmd_t                        cmd,
  output logic [DIGIT_W-1:0]                rd_data,
  output logic [$clog2(MAX_DIGITS+1)-1:0]   depth
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int DW = $clog2(MAX_DIGITS + 1);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DW-1:0]      depth_m1;
  logic               full;

  assign depth_m1 = depth - 1'b1;
  assign full     = (depth == DW'(MAX_DIGITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push && !full) begin
      depth <= depth + 1'b1;
    end else if (cmd.pop && depth != '0) begin
      depth <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[depth[AW-1:0]] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_data <= mem[depth_m1[AW-1:0]];
    end
  end

endmodule

// ===== hdl/radix_digit_converter_core.sv =====
// Flow: the shared divider produces each digit as a remainder, which is pushed
// onto the digit stack; the digits are then popped and shown through ST_POP,
// ST_WAIT and ST_OUT (held by any output stall). A zero value gives no beats.
// Throughput: one value at a time; in_stall stays high until the final digit beat.
// Reset (rst, synchronous): radix returns to 10, sequencer idle, stack empty.
module radix_digit_converter_core import rdc_pkg::*; #(
  parameter int MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIGIT_W-1:0] digit,
  output logic               last_digit,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int DW = $clog2(MAX_DIGITS + 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a value
  localparam logic [2:0] ST_DIV  = 3'd1;  // divider running, digits pushed
  localparam logic [2:0] ST_POP  = 3'd2;  // issue stack read
  localparam logic [2:0] ST_WAIT = 3'd3;  // read data lands
  localparam logic [2:0] ST_OUT  = 3'd4;  // digit beat on offer

  logic [2:0]         state;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_lat;
  logic               in_accept;
  logic               cfg_write;

  div_result_t        div_res;
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;

  stack_cmd_t         stk_cmd;
  logic [DIGIT_W-1:0] stk_rd_data;
  logic [DW-1:0]      stk_depth;

  // ---------------------------------------------------------------------
  // Configuration: one register, radix, at byte address 0
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_write && paddr[2] == REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RADIX) ? DATA_W'(radix) : '0;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // first division takes the new value, every later one the last quotient
  assign div_start = (in_accept && value != '0) ||
                     (state == ST_DIV && div_res.done && div_res.quotient != '0);
  assign div_dividend = (state == ST_IDLE) ? value : div_res.quotient;

  // push each remainder as it comes out of the divider
  assign stk_cmd.push = (state == ST_DIV) && div_res.done;
  assign stk_cmd.data = div_res.remainder;
  assign stk_cmd.pop  = (state == ST_POP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // a zero value has no digits: stay idle
          if (in_accept && value != '0) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done && div_res.quotient == '0) begin
            state <= ST_POP;
          end
        end
        ST_POP: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          out_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          // drop the beat once taken, then pop the next digit or finish
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= last_digit ? ST_IDLE : ST_POP;
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      // radix 0 and 1 saturate to 2
      radix_lat <= (radix < RADIX_MIN) ? RADIX_MIN : radix;
    end
    if (state == ST_WAIT) begin
      digit      <= stk_rd_data;
      last_digit <= (stk_depth == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Shared divider and digit stack
  // ---------------------------------------------------------------------
  rdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ((state == ST_IDLE) ? ((radix < RADIX_MIN) ? RADIX_MIN : radix)
                                  : radix_lat),
    .result   (div_res)
  );

  rdc_stack #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (stk_cmd),
    .rd_data (stk_rd_data),
    .depth   (stk_depth)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("divider finished outside the division phase");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_digit) |-> (stk_depth == '0))
    else $error("last digit flagged while stack still holds digits");

  a_zero_no_work: assert property (@(posedge clk) disable iff (rst)
    (in_accept && value == '0) |=> (state == ST_IDLE && !out_valid))
    else $error("zero value started a conversion");

  a_beat_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT))
    else $error("digit beat offered outside the output phase");

endmodule
